// File: hdl/text_mode_terminal_writer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text-mode terminal writer
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_WRITER_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_MACROS_SVH

// Same-cycle implication
`define TMTW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tmtw same-cycle check failed");

// Next-cycle implication
`define TMTW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmtw next-cycle check failed");

`endif

// File: hdl/tmtw_pkg.sv
// ----------------------------------------------------------------------------
// tmtw_pkg
// Types and constants shared by the text-mode terminal writer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmtw_pkg;

  // Default screen geometry
  localparam int unsigned DEF_COLUMNS = 80;
  localparam int unsigned DEF_ROWS    = 25;

  // One cell: attribute byte over character byte
  localparam int unsigned CELL_W = 16;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h07;

  // Register port geometry
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TEXT_ATTRIBUTE = '0;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } cmd_word_t;

  typedef struct packed {
    logic [4:0]        cursor_row;
    logic [6:0]        cursor_col;
    logic              scrolled;
    logic [CELL_W-1:0] cell_value;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_SCROLL_END
  } ctrl_state_t;

endpackage

// File: hdl/tmtw_ram.sv
// ----------------------------------------------------------------------------
// tmtw_ram
// Screen cell memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtw_ram
  import tmtw_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_ROWS * DEF_COLUMNS,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CELL_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CELL_W-1:0] wr_data
);

  logic [CELL_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/tmtw_outq.sv
// ----------------------------------------------------------------------------
// tmtw_outq
// Two-entry response queue between the controller and the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtw_outq
  import tmtw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rsp_word_t push_word,
  output logic      full,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp
);

  rsp_word_t  head;
  rsp_word_t  tail;
  logic [1:0] count;
  logic       pop;

  assign pop       = rsp_valid && rsp_ready;
  assign rsp_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign rsp       = head;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Entries; head is always the oldest word
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          head <= push_word;
        end else begin
          tail <= push_word;
        end
      end
      2'b01: begin
        head <= tail;
      end
      2'b11: begin
        if (count == 2'd1) begin
          head <= push_word;
        end else begin
          head <= tail;
          tail <= push_word;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/tmtw_ctrl.sv
// ----------------------------------------------------------------------------
// tmtw_ctrl
// Command sequencer: cursor, character writes, clear and scroll sweeps over
// the cell memory, and cell reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtw_ctrl
  import tmtw_pkg::*;
#(
  parameter int unsigned COLUMNS = DEF_COLUMNS,
  parameter int unsigned ROWS    = DEF_ROWS,
  localparam int unsigned TOTAL  = ROWS * COLUMNS,
  localparam int unsigned ADDR_W = $clog2(TOTAL)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        attr,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_word_t         cmd,
  input  logic              q_full,
  output logic              push,
  output rsp_word_t         push_word,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [CELL_W-1:0] rd_data,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [CELL_W-1:0] wr_data
);

  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned COL_W = $clog2(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

  ctrl_state_t       state, state_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ADDR_W-1:0] sweep, sweep_next;
  logic [ADDR_W-1:0] dst, dst_next;
  logic              pend, pend_next;
  logic              scrolled;
  logic [CELL_W-1:0] rd_cell;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] cell_addr;
  logic              cell_hit;
  logic              accept;

  // Linear addresses of the cursor and of the requested cell
  assign cur_addr  = ADDR_W'(row) * ROW_STEP + ADDR_W'(col);
  assign cell_addr = ADDR_W'(cmd.read_row) * ROW_STEP + ADDR_W'(cmd.read_col);
  assign cell_hit  = (32'(cmd.read_row) < ROWS) && (32'(cmd.read_col) < COLUMNS);
  assign accept    = cmd_valid && cmd_ready;

  // State and cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
      col   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      pend  <= pend_next;
    end
  end

  // Sweep address and delayed scroll destination
  always_ff @(posedge clk) begin
    sweep <= sweep_next;
    dst   <= dst_next;
  end

  // Next state, memory requests and responses
  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    sweep_next = sweep;
    dst_next   = dst;
    pend_next  = pend;
    cmd_ready  = 1'b0;
    push       = 1'b0;
    scrolled   = 1'b0;
    rd_cell    = '0;
    rd_en      = 1'b0;
    rd_addr    = sweep;
    wr_en      = 1'b0;
    wr_addr    = cur_addr;
    wr_data    = {attr, cmd.char_code};

    case (state)
      ST_IDLE: begin
        cmd_ready = !q_full;
        if (accept) begin
          case (cmd.opcode)
            OP_PUT: begin
              wr_en = (cmd.char_code != NEWLINE_CODE);
              if (cmd.char_code == NEWLINE_CODE || col == LAST_COL) begin
                col_next = '0;
                if (row == LAST_ROW) begin
                  // scroll: sweep sources start one row down
                  state_next = ST_SCROLL;
                  sweep_next = ROW_STEP;
                  pend_next  = 1'b0;
                end else begin
                  row_next = row + ROW_W'(1);
                  push     = 1'b1;
                end
              end else begin
                col_next = col + COL_W'(1);
                push     = 1'b1;
              end
            end
            OP_CLEAR: begin
              row_next   = '0;
              col_next   = '0;
              sweep_next = '0;
              state_next = ST_CLEAR;
            end
            OP_READ: begin
              if (cell_hit) begin
                rd_en      = 1'b1;
                rd_addr    = cell_addr;
                state_next = ST_READ;
              end else begin
                push = 1'b1;
              end
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        rd_cell    = rd_data;
        push       = 1'b1;
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep;
        wr_data = {attr, SPACE_CODE};
        if (sweep == LAST_ADDR) begin
          push       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          sweep_next = sweep + ADDR_W'(1);
        end
      end
      ST_SCROLL: begin
        // read cell k+COLUMNS, write the previous read back one row up
        rd_en     = 1'b1;
        wr_en     = pend;
        wr_addr   = dst;
        wr_data   = rd_data;
        pend_next = 1'b1;
        dst_next  = sweep - ROW_STEP;
        if (sweep == LAST_ADDR) begin
          state_next = ST_SCROLL_END;
        end else begin
          sweep_next = sweep + ADDR_W'(1);
        end
      end
      ST_SCROLL_END: begin
        wr_en      = 1'b1;
        wr_addr    = dst;
        wr_data    = rd_data;
        pend_next  = 1'b0;
        scrolled   = 1'b1;
        push       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign push_word = '{cursor_row: 5'(row_next),
                       cursor_col: 7'(col_next),
                       scrolled:   scrolled,
                       cell_value: rd_cell};

endmodule

// File: hdl/text_mode_terminal_writer.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Text-mode screen writer: ROWS x COLUMNS cells of attribute and character,
// a cursor, newline handling, scroll on overflow, clear and cell read.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one command word: put a
//   character, clear and home, or read one cell. rsp channel returns one
//   word per command with the cursor after it, a scroll flag and the cell.
//   text_attribute sits at register address 0 of the APB port.
// Timing:
//   A put that does not scroll, a read out of range and the unused opcode
//   push their response in the accepting cycle; puts stream at one per
//   cycle while the response queue has room and no scroll is under way. A
//   read pushes its response from ST_READ, the cell memory having registered read data.
//   A clear takes the accepting cycle, then walks every cell, one write per
//   cycle. A scroll copies (ROWS-1)*COLUMNS cells through the memory's read
//   and write ports, one per cycle after the accepting cycle, with the last
//   write made in ST_SCROLL_END.
// Reset homes the cursor and loads attribute 0x07; cell contents stay
//   undefined until the first clear.
// Responses go through a two-entry queue; when both entries are held the
//   block stops taking commands until the receiver drains one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_mode_terminal_writer
  import tmtw_pkg::*;
#(
  parameter int unsigned COLUMNS = DEF_COLUMNS,
  parameter int unsigned ROWS    = DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_word_t          cmd,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_word_t          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned TOTAL  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(TOTAL);

  logic [7:0]        attr;
  logic              attr_sel;
  logic              q_full;
  logic              push;
  rsp_word_t         push_word;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;

  // Register port
  assign pready   = 1'b1;
  assign attr_sel = (paddr[PADDR_W-1:2] == REG_TEXT_ATTRIBUTE);
  assign prdata   = attr_sel ? PDATA_W'(attr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && attr_sel) begin
      attr <= pwdata[7:0];
    end
  end

  tmtw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .attr      (attr),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  tmtw_ram #(
    .DEPTH (TOTAL)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  tmtw_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: hdl/tmtw_checker.sv
// ----------------------------------------------------------------------------
// tmtw_checker
// Port-level checks for the text-mode terminal writer, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_mode_terminal_writer_macros.svh"

module tmtw_checker
  import tmtw_pkg::*;
#(
  parameter int unsigned COLUMNS = DEF_COLUMNS,
  parameter int unsigned ROWS    = DEF_ROWS
) (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input rsp_word_t          rsp,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  // Cursor reported on the screen
  `TMTW_ASSERT_IMP(a_cursor_range, rsp_valid, (32'(rsp.cursor_row) < ROWS) && (32'(rsp.cursor_col) < COLUMNS))

  // A scroll leaves the cursor at the start of the bottom row
  `TMTW_ASSERT_IMP(a_scroll_pos, rsp_valid && rsp.scrolled, (rsp.cursor_row == 5'(ROWS - 1)) && (rsp.cursor_col == 7'd0))

  // Attribute write reads back on the next cycle
  `TMTW_ASSERT_NXT(a_attr_readback, psel && penable && pwrite && pready && !paddr[2], paddr[2] || (prdata[7:0] == $past(pwdata[7:0])))

  // Stalled response word holds
  `TMTW_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind text_mode_terminal_writer tmtw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tmtw_checker (.*);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: text-mode terminal writer testbench
// Drives command words through the valid/ready port and predicts every
// response word: cursor position, scroll flag and cell value. The screen
// contents are mirrored here. The run opens with a clear, then a directed
// set of words, then four phases of random text lines, newline runs, long
// wrapping lines, cell reads and noise. The text attribute is rewritten over
// APB between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tmtw_pkg::*;

  localparam int SCREEN_COLS = DEF_COLUMNS;
  localparam int SCREEN_ROWS = DEF_ROWS;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int CMD_W = $bits(cmd_word_t);
  localparam logic [PADDR_W-1:0] ATTR_ADDR = {REG_TEXT_ATTRIBUTE, 2'b00};
  localparam int RANDOM_PER_PHASE = 125;
  localparam int MAX_PRINTED = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_word_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_word_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  text_mode_terminal_writer dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Mirror of the screen, cursor and attribute
  logic [CELL_W-1:0] screen_mirror [SCREEN_CELLS];
  int cur_row = 0;
  int cur_col = 0;
  logic [7:0] text_attr = ATTR_RESET;

  cmd_word_t cmd_backlog[$];
  rsp_word_t due_rsp_words[$];
  bit cmd_taken = 1'b0;
  int send_gap_pct = 0;
  int sink_stall_pct = 0;

  int mismatch_count = 0;
  int n_cmds = 0, n_scrolls = 0, n_clears = 0, n_reads = 0, n_reads_oob = 0;
  int n_nops = 0;

  // Clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED)
      $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Cursor to column 0 of next row; scroll whole rows up at the bottom
  function automatic bit advance_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= SCREEN_ROWS) begin
      for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
        screen_mirror[i] = screen_mirror[i + SCREEN_COLS];
      cur_row = SCREEN_ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one command word to the mirror and return the response it yields
  function automatic rsp_word_t apply_terminal_cmd(input cmd_word_t c);
    rsp_word_t r;
    r = '0;
    case (opcode_t'(c.opcode))
      OP_PUT: begin
        if (c.char_code == NEWLINE_CODE) begin
          r.scrolled = advance_row();
        end else begin
          screen_mirror[cur_row * SCREEN_COLS + cur_col] = {text_attr, c.char_code};
          cur_col++;
          if (cur_col >= SCREEN_COLS) r.scrolled = advance_row();
        end
      end
      OP_CLEAR: begin
        foreach (screen_mirror[i]) screen_mirror[i] = {text_attr, SPACE_CODE};
        cur_row = 0;
        cur_col = 0;
      end
      OP_READ: begin
        if (c.read_row < SCREEN_ROWS && c.read_col < SCREEN_COLS)
          r.cell_value = screen_mirror[c.read_row * SCREEN_COLS + c.read_col];
      end
      default: ;
    endcase
    r.cursor_row = cur_row[4:0];
    r.cursor_col = cur_col[6:0];
    return r;
  endfunction

  // Driver: new word at the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        cmd <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
    rsp_ready <= !rst && ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: predict on accepted commands, compare accepted responses
  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      cmd_taken = 1'b0;
    end else begin
      cmd_taken = cmd_valid && cmd_ready;
      if (cmd_taken) begin
        want = apply_terminal_cmd(cmd);
        due_rsp_words.push_back(want);
        n_cmds++;
        n_scrolls += want.scrolled;
        case (opcode_t'(cmd.opcode))
          OP_CLEAR: n_clears++;
          OP_READ: begin
            n_reads++;
            if (cmd.read_row >= SCREEN_ROWS || cmd.read_col >= SCREEN_COLS) n_reads_oob++;
          end
          OP_NOP: n_nops++;
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (due_rsp_words.size() == 0) begin
          flag_mismatch("response word with nothing outstanding");
        end else begin
          want = due_rsp_words.pop_front();
          if (rsp.cursor_row !== want.cursor_row)
            flag_mismatch($sformatf("cursor_row %0d, want %0d", rsp.cursor_row,
                                    want.cursor_row));
          if (rsp.cursor_col !== want.cursor_col)
            flag_mismatch($sformatf("cursor_col %0d, want %0d", rsp.cursor_col,
                                    want.cursor_col));
          if (rsp.scrolled !== want.scrolled)
            flag_mismatch($sformatf("scrolled %b, want %b", rsp.scrolled, want.scrolled));
          if (rsp.cell_value !== want.cell_value)
            flag_mismatch($sformatf("cell_value %h, want %h", rsp.cell_value,
                                    want.cell_value));
        end
      end
    end
  end

  // Stimulus helpers; queue_cmd fills the read coordinates at random over their full width
  task automatic queue_cmd(input opcode_t op, input logic [7:0] ch);
    cmd_word_t w;
    w.opcode = op;
    w.char_code = ch;
    w.read_row = 5'($urandom);
    w.read_col = 7'($urandom);
    cmd_backlog.push_back(w);
  endtask

  task automatic queue_read(input logic [4:0] row, input logic [6:0] col);
    cmd_word_t w;
    w.opcode = OP_READ;
    w.char_code = 8'($urandom);
    w.read_row = row;
    w.read_col = col;
    cmd_backlog.push_back(w);
  endtask

  // Mostly well-formed text traffic with reads, clears and some noise
  task automatic queue_random_traffic(input int target);
    int made, kind, len;
    cmd_word_t w;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // short line of text closed by a newline
        len = $urandom_range(12);
        repeat (len) queue_cmd(OP_PUT, 8'($urandom));
        queue_cmd(OP_PUT, NEWLINE_CODE);
        made += len + 1;
      end else if (kind < 50) begin
        // run of newlines that may reach the bottom and scroll
        len = $urandom_range(12, 2);
        repeat (len) queue_cmd(OP_PUT, NEWLINE_CODE);
        made += len;
      end else if (kind < 54) begin
        // long line that may wrap at the row end
        len = $urandom_range(90, 70);
        repeat (len) queue_cmd(OP_PUT, 8'($urandom));
        made += len;
      end else if (kind < 84) begin
        // a few reads, mostly on screen
        len = $urandom_range(4, 1);
        repeat (len) begin
          if ($urandom_range(3) == 0) queue_read(5'($urandom), 7'($urandom));
          else queue_read(5'($urandom_range(SCREEN_ROWS - 1)),
                          7'($urandom_range(SCREEN_COLS - 1)));
        end
        made += len;
      end else if (kind < 97) begin
        // noise: any word at all
        w = cmd_word_t'(CMD_W'($urandom));
        cmd_backlog.push_back(w);
        if (w.opcode != OP_NOP) made++;
      end else begin
        queue_cmd(OP_CLEAR, 8'($urandom));
        made++;
      end
    end
  endtask

  task automatic apb_write_attr(input logic [7:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ATTR_ADDR;
    pwdata <= {{(PDATA_W - 8){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    text_attr = value;
  endtask

  task automatic apb_check_attr();
    logic [PDATA_W-1:0] got;
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= ATTR_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[7:0] !== text_attr)
      flag_mismatch($sformatf("text_attribute reads %h, want %h", got[7:0], text_attr));
  endtask

  // Hold off until every response is back, then let the block settle
  task automatic drain_responses();
    while (cmd_backlog.size() > 0 || cmd_valid || due_rsp_words.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Main sequence
  initial begin
    logic [7:0] phase_attr [4];
    int gap_plan [4];
    int stall_plan [4];
    phase_attr = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom)};
    gap_plan = '{0, 75, 0, 25};
    stall_plan = '{0, 0, 75, 25};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    apb_check_attr();

    // Directed: clear first so no cell is ever read unwritten
    queue_cmd(OP_CLEAR, 8'h00);
    queue_read(5'd0, 7'd0);
    queue_cmd(OP_PUT, 8'h00);
    queue_cmd(OP_PUT, 8'hFF);
    queue_cmd(OP_PUT, 8'h80);
    queue_cmd(OP_PUT, 8'h7F);
    queue_read(5'd0, 7'd1);
    queue_read(5'd0, 7'd2);
    queue_cmd(OP_PUT, NEWLINE_CODE);
    queue_cmd(OP_PUT, 8'h41);
    queue_read(5'd1, 7'd0);
    queue_read(5'd0, 7'd3);
    queue_read(5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1));
    // reads off the screen give a zero cell
    queue_read(5'(SCREEN_ROWS), 7'd0);
    queue_read(5'd31, 7'd127);
    queue_read(5'd0, 7'(SCREEN_COLS));
    queue_read(5'(SCREEN_ROWS - 1), 7'd127);
    // unused opcode leaves everything as it was
    queue_cmd(OP_NOP, 8'hFF);
    queue_cmd(OP_NOP, 8'h00);
    queue_cmd(OP_PUT, NEWLINE_CODE);
    queue_read(5'd0, 7'd0);
    drain_responses();

    for (int p = 0; p < 4; p++) begin
      apb_write_attr(phase_attr[p]);
      @(negedge clk);
      apb_check_attr();
      send_gap_pct = gap_plan[p];
      sink_stall_pct = stall_plan[p];
      queue_random_traffic(RANDOM_PER_PHASE);
      drain_responses();
    end

    repeat (8) @(negedge clk);
    $display("Ran %0d commands: %0d scrolls, %0d clears, %0d unused-opcode words,",
             n_cmds, n_scrolls, n_clears, n_nops);
    $display("%0d cell reads (%0d off screen), five attribute settings.",
             n_reads, n_reads_oob);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
